// ===== src/fab_pkg.sv =====
`timescale 1ns / 1ps
// Package for the fit-policy block allocator: payload structs, policy and
// request codes, register indexes, FSM states and the cell interface types.
package fab_pkg;

  // Request kinds carried in req_type.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // Configuration register indexes.
  localparam logic REG_FIT_POLICY    = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  // Fit policies; the unused code behaves as first fit.
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fab_policy_t;

  localparam logic [1:0] POLICY_RESET = 2'd0;
  localparam logic [3:0] BLOCKS_RESET = 4'd8;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  block_index;
    logic [15:0] amount;
  } fab_in_t;

  typedef struct packed {
    logic        granted;
    logic [2:0]  block_chosen;
    logic [15:0] remaining_after;
  } fab_out_t;

  // Control part of the search token that walks down the cell chain.
  typedef struct packed {
    logic valid;
    logic found;
  } fab_tok_t;

  // Per-cell controls driven by the top level.
  typedef struct packed {
    logic in_use;
    logic load_en;
    logic sub_en;
  } fab_cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } fab_state_t;

endpackage

// ===== src/fab_cell.sv =====
`timescale 1ns / 1ps
// One cell of the allocator chain: holds one block's remaining capacity and
// updates the passing search token. Depends on fab_pkg.
module fab_cell #(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 3,
  parameter int CMP_W     = 16,
  parameter int CELL_IDX  = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fab_pkg::fab_cell_ctl_t ctl_i,
  input  logic [1:0]            policy_i,
  input  logic [CMP_W-1:0]      amt_i,
  input  logic [SIZE_BITS-1:0]  load_val_i,
  input  logic [SIZE_BITS-1:0]  sub_amt_i,
  input  fab_pkg::fab_tok_t     tok_i,
  input  logic [SIZE_BITS-1:0]  cap_i,
  input  logic [IDX_W-1:0]      idx_i,
  output fab_pkg::fab_tok_t     tok_o,
  output logic [SIZE_BITS-1:0]  cap_o,
  output logic [IDX_W-1:0]      idx_o
);
  import fab_pkg::*;

  logic [SIZE_BITS-1:0] cap_r, cap_nxt;
  fab_tok_t             tok_r, tok_nxt;
  logic [SIZE_BITS-1:0] best_cap_r, best_cap_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic                 fits;
  logic                 take;

  always_comb begin
    fits = ctl_i.in_use && (CMP_W'(cap_r) >= amt_i);
    take = fits && (!tok_i.found ||
                    (policy_i == FIT_BEST  && cap_r < cap_i) ||
                    (policy_i == FIT_WORST && cap_r > cap_i));
    tok_nxt.valid = tok_i.valid;
    tok_nxt.found = tok_i.found || (tok_i.valid && fits);
    if (tok_i.valid && take) begin
      best_cap_nxt = cap_r;
      best_idx_nxt = IDX_W'(CELL_IDX);
    end else begin
      best_cap_nxt = cap_i;
      best_idx_nxt = idx_i;
    end
    if (ctl_i.load_en) begin
      cap_nxt = load_val_i;
    end else if (ctl_i.sub_en) begin
      cap_nxt = cap_r - sub_amt_i;
    end else begin
      cap_nxt = cap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
      tok_r <= '0;
    end else begin
      cap_r <= cap_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_cap_r <= best_cap_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign tok_o = tok_r;
  assign cap_o = best_cap_r;
  assign idx_o = best_idx_r;

endmodule

// ===== src/fit_policy_block_allocator_core.sv =====
`timescale 1ns / 1ps
// Fit-policy block allocator: a load item writes the addressed cell when taken;
// an allocate item sends a search token stepping through one capacity cell per
// cycle. Either result then passes the result and output registers. One item is
// in work at a time: no new item is taken until the last result is in the output
// register. Synchronous active-low reset clears all capacities to zero, the policy
// to first fit and blocks_in_use to 8. Depends on fab_pkg and fab_cell.
module fit_policy_block_allocator_core #(
  parameter int NUM_BLOCKS = 8,
  parameter int SIZE_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fab_pkg::fab_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fab_pkg::fab_out_t out_data,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [3:0]       cfg_wdata
);
  import fab_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CMP_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;

  // Configuration registers.
  logic [1:0] policy_r;
  logic [3:0] blocks_r;

  // Control and datapath registers.
  fab_state_t       state_r, state_nxt;
  logic             start_r;
  logic [CMP_W-1:0] amt_r;
  fab_out_t         res_r, res_nxt;
  logic             out_valid_r;
  fab_out_t         out_data_r;

  // Decoded control.
  logic ld_go;
  logic alloc_go;
  logic scan_end;
  logic commit;
  logic res_load;
  logic out_load;

  // The chain: entry j feeds cell j, entry NUM_BLOCKS is the last cell's output.
  fab_tok_t             tok   [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] cap_ch[NUM_BLOCKS+1];
  logic [IDX_W-1:0]     idx_ch[NUM_BLOCKS+1];
  fab_cell_ctl_t        ctl   [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] chain_valid;

  logic [SIZE_BITS-1:0] load_val;
  logic [SIZE_BITS-1:0] sub_amt;
  logic                 ld_in_range;
  logic [CMP_W-1:0]     left_after;

  // The user must issue configuration writes only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_RESET;
      blocks_r <= BLOCKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FIT_POLICY:    policy_r <= cfg_wdata[1:0];
        REG_BLOCKS_IN_USE: blocks_r <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.req_type == REQ_ALLOC) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (tok[NUM_BLOCKS].valid) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output decode of the state machine.
  always_comb begin
    in_ready = 1'b0;
    ld_go    = 1'b0;
    alloc_go = 1'b0;
    scan_end = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ld_go    = in_valid && (in_data.req_type == REQ_LOAD);
        alloc_go = in_valid && (in_data.req_type == REQ_ALLOC);
      end
      ST_SCAN: scan_end = tok[NUM_BLOCKS].valid;
      ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign commit   = scan_end && tok[NUM_BLOCKS].found;
  assign res_load = ld_go || scan_end;

  // A load writes its masked amount straight into the addressed cell; block
  // indexes beyond the table are refused.
  assign load_val    = SIZE_BITS'(in_data.amount);
  assign ld_in_range = (32'(in_data.block_index) < NUM_BLOCKS);
  assign sub_amt     = SIZE_BITS'(amt_r);
  assign left_after  = CMP_W'(cap_ch[NUM_BLOCKS]) - amt_r;

  always_comb begin
    res_nxt = '0;
    if (ld_go) begin
      if (ld_in_range) begin
        res_nxt.granted         = 1'b1;
        res_nxt.block_chosen    = in_data.block_index;
        res_nxt.remaining_after = 16'(load_val);
      end
    end else if (commit) begin
      res_nxt.granted         = 1'b1;
      res_nxt.block_chosen    = 3'(idx_ch[NUM_BLOCKS]);
      res_nxt.remaining_after = 16'(left_after);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= alloc_go;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_go) begin
      amt_r <= CMP_W'(in_data.amount);
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The token enters cell 0 in the cycle after the allocate item is taken.
  assign tok[0].valid = start_r;
  assign tok[0].found = 1'b0;
  assign cap_ch[0]    = '0;
  assign idx_ch[0]    = '0;

  for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_cell
    assign ctl[j].in_use  = (j < 32'(blocks_r));
    assign ctl[j].load_en = ld_go && ld_in_range && (32'(in_data.block_index) == j);
    assign ctl[j].sub_en  = commit && (32'(idx_ch[NUM_BLOCKS]) == j);
    assign chain_valid[j] = tok[j+1].valid;

    fab_cell #(
      .SIZE_BITS(SIZE_BITS),
      .IDX_W    (IDX_W),
      .CMP_W    (CMP_W),
      .CELL_IDX (j)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl[j]),
      .policy_i  (policy_r),
      .amt_i     (amt_r),
      .load_val_i(load_val),
      .sub_amt_i (sub_amt),
      .tok_i     (tok[j]),
      .cap_i     (cap_ch[j]),
      .idx_i     (idx_ch[j]),
      .tok_o     (tok[j+1]),
      .cap_o     (cap_ch[j+1]),
      .idx_o     (idx_ch[j+1])
    );
  end

`ifndef SYNTHESIS
  // Only one search token can be in the chain at a time.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_valid))
    else $error("more than one search token in the cell chain");

  // No token walks the chain while the block waits for a new item.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (chain_valid == '0))
    else $error("search token present while idle");

  // A block picked by the search really fits the request.
  a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (CMP_W'(cap_ch[NUM_BLOCKS]) >= amt_r))
    else $error("chosen block is smaller than the request");

  // A refused item reports block zero and nothing left.
  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !res_r.granted) |->
      (res_r.block_chosen == 3'd0 && res_r.remaining_after == 16'd0))
    else $error("refused result carries a nonzero block or capacity");
`endif

endmodule
